### src/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants for the vertex normal accumulator: store sizes,
// datapath widths, item kinds, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package vna_pkg;

    // Store geometry and field widths
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int COORD_BITS   = 16;
    localparam int ACCUM_BITS   = 48;
    localparam int VCOUNT_W     = 11;
    localparam int CORNER_W     = 12;
    localparam int INDEX_W      = 10;
    localparam int NORM_W       = 16;
    localparam int TOTAL_W      = 32;

    // Cross product widths
    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;

    // Normalization widths: magnitudes land in [2^29, 2^30)
    localparam int UNIT_W  = 30;
    localparam int SQ_W    = 2 * UNIT_W;
    localparam int SUM_W   = 64;
    localparam int LEN_W   = 31;
    localparam int FRAC_W  = 14;
    localparam int NUM_W   = UNIT_W + FRAC_W + 1;
    localparam int QUOT_W  = 16;
    localparam int REM_W   = LEN_W + 1;
    localparam int CNT_W   = 5;

    localparam int POS_WORD_W = 3 * COORD_BITS;
    localparam int ACC_WORD_W = 3 * ACCUM_BITS;

    // Item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_TRI  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_DEGEN     = 2'd2;
    localparam logic [1:0] ST_UNNORMED  = 2'd3;

    // Sequencer states, one-hot
    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_TRD   = 13'b0000000000100,
        S_TEDGE = 13'b0000000001000,
        S_TMUL  = 13'b0000000010000,
        S_TCHK  = 13'b0000000100000,
        S_TACC  = 13'b0000001000000,
        S_RRD   = 13'b0000010000000,
        S_RCAP  = 13'b0000100000000,
        S_RNORM = 13'b0001000000000,
        S_RSQ   = 13'b0010000000000,
        S_RSQRT = 13'b0100000000000,
        S_RDIV  = 13'b1000000000000
    } t_state;

    // Saturating add of a cross product component to an accumulator
    function automatic logic signed [ACCUM_BITS-1:0] sat_add(
        input logic signed [ACCUM_BITS-1:0] acc,
        input logic signed [CROSS_W-1:0]    inc
    );
        logic signed [ACCUM_BITS:0] sum;
        logic signed [ACCUM_BITS-1:0] res;
        sum = (ACCUM_BITS+1)'(acc) + (ACCUM_BITS+1)'(inc);
        if (sum[ACCUM_BITS] != sum[ACCUM_BITS-1]) begin
            res = sum[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                                  : {1'b0, {(ACCUM_BITS-1){1'b1}}};
        end else begin
            res = sum[ACCUM_BITS-1:0];
        end
        return res;
    endfunction

endpackage

### src/vertex_normal_accumulator_core.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_core
// Area-weighted vertex normals: position store, cross product of triangle
// edges accumulated into per-vertex sums, and normalized readout with clear.
// ----------------------------------------------------------------------------
// Readouts pass through a normalizing shift of one bit per cycle, an integer square
// root and a divide per component; a zero sum skips the root and the divide.
// Degenerate triangles skip the accumulation.
// Throughput: one item at a time; the next item is taken once the result sits
// in the output register, so a stalled result holds back the next result and then the input.
// Reset: a clearing pass then zeroes all 1024 accumulator entries; config writes taken throughout.
module vertex_normal_accumulator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [10:0]                    i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_kind,
    input  logic [9:0]                     i_vertex_index,
    input  logic signed [15:0]             i_pos_x,
    input  logic signed [15:0]             i_pos_y,
    input  logic signed [15:0]             i_pos_z,
    input  logic [11:0]                    i_corner_a,
    input  logic [11:0]                    i_corner_b,
    input  logic [11:0]                    i_corner_c,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic signed [15:0]             o_normal_x,
    output logic signed [15:0]             o_normal_y,
    output logic signed [15:0]             o_normal_z,
    output logic [31:0]                    o_degenerate_total,
    output logic [31:0]                    o_unnormed_total
);

    localparam int AW  = vna_pkg::ADDR_W;
    localparam int CB  = vna_pkg::COORD_BITS;
    localparam int AB  = vna_pkg::ACCUM_BITS;
    localparam int VW  = vna_pkg::VCOUNT_W;
    localparam int CRW = vna_pkg::CORNER_W;
    localparam int EW  = vna_pkg::EDGE_W;
    localparam int PW  = vna_pkg::PROD_W;
    localparam int XW  = vna_pkg::CROSS_W;
    localparam int UW  = vna_pkg::UNIT_W;
    localparam int QW  = vna_pkg::SQ_W;
    localparam int SW  = vna_pkg::SUM_W;
    localparam int LW  = vna_pkg::LEN_W;
    localparam int FW  = vna_pkg::FRAC_W;
    localparam int NW  = vna_pkg::NUM_W;
    localparam int DW  = vna_pkg::QUOT_W;
    localparam int RW  = vna_pkg::REM_W;
    localparam int CW  = vna_pkg::CNT_W;
    localparam int TW  = vna_pkg::TOTAL_W;
    localparam int OW  = vna_pkg::NORM_W;
    localparam int PWW = vna_pkg::POS_WORD_W;
    localparam int AWW = vna_pkg::ACC_WORD_W;

    // Memories
    logic [PWW-1:0] pos_mem [vna_pkg::MAX_VERTICES];
    logic [AWW-1:0] acc_mem [vna_pkg::MAX_VERTICES];
    logic [PWW-1:0] r_pos_rd;
    logic [AWW-1:0] r_acc_rd;

    logic           pos_we;
    logic [AW-1:0]  pos_raddr;
    logic           acc_we;
    logic [AW-1:0]  acc_waddr;
    logic [AW-1:0]  acc_raddr;
    logic [AWW-1:0] acc_wdata;

    // Control registers
    vna_pkg::t_state r_state;
    logic [VW-1:0]   r_vcount;
    logic [AW-1:0]   r_clr_addr;
    logic [CW-1:0]   r_cnt;
    logic [1:0]      r_k;
    logic            r_out_valid;
    logic [TW-1:0]   r_degen;
    logic [TW-1:0]   r_unnorm;

    // Datapath registers
    logic [AW-1:0]          r_idx;
    logic [AW-1:0]          r_corner [3];
    logic signed [CB-1:0]   r_pos [3][3];
    logic signed [EW-1:0]   r_e1 [3];
    logic signed [EW-1:0]   r_e2 [3];
    logic signed [PW-1:0]   r_p1;
    logic signed [PW-1:0]   r_p2;
    logic signed [XW-1:0]   r_n [3];
    logic [1:0]             r_status;
    logic signed [OW-1:0]   r_nrm [3];
    logic [AB-1:0]          r_u [3];
    logic                   r_neg [3];
    logic [AB-1:0]          r_m;
    logic [QW-1:0]          r_sq;
    logic [SW-1:0]          r_s;
    logic [SW-1:0]          r_root;
    logic [SW-1:0]          r_bit;
    logic [LW-1:0]          r_len;
    logic [RW-1:0]          r_drem;
    logic [DW-1:0]          r_dlow;
    logic [DW-1:0]          r_quot;

    // Output registers
    logic [1:0]             r_out_status;
    logic signed [OW-1:0]   r_out_nrm [3];
    logic [TW-1:0]          r_out_degen;
    logic [TW-1:0]          r_out_unnorm;

    // Combinational helpers
    logic [VW-1:0]          lim;
    logic                   in_acc;
    logic                   out_free;
    logic [1:0]             sel;
    logic signed [AB-1:0]   a_rd [3];
    logic [AB-1:0]          mag [3];
    logic [AB-1:0]          mag_max;
    logic [SW-1:0]          sq_try;
    logic [NW-1:0]          num;
    logic [RW-1:0]          d_try;
    logic [AWW-1:0]         acc_sum;

    // Effective vertex limit
    assign lim = (r_vcount < VW'(vna_pkg::MAX_VERTICES)) ? r_vcount
                                                          : VW'(vna_pkg::MAX_VERTICES);

    // Take a new item only in IDLE and when no finished item waits to be posted
    assign o_in_ready = (r_state == vna_pkg::S_IDLE) && !r_cnt[0];
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign sel        = r_cnt[2:1];

    // Unpack the accumulator read word and take magnitudes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_rd[k] = r_acc_rd[k*AB +: AB];
            mag[k]  = a_rd[k][AB-1] ? (~r_acc_rd[k*AB +: AB] + AB'(1))
                                    : r_acc_rd[k*AB +: AB];
        end
        mag_max = mag[0];
        if (mag[1] > mag_max) begin
            mag_max = mag[1];
        end
        if (mag[2] > mag_max) begin
            mag_max = mag[2];
        end
    end

    // Saturating sums for the corner under update
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_sum[k*AB +: AB] = vna_pkg::sat_add(a_rd[k], r_n[k]);
        end
    end

    // Square root trial and divider setup and trial
    assign sq_try = r_root + r_bit;
    assign num    = {1'b0, r_u[r_k][UW-1:0], {FW{1'b0}}} + NW'(r_len >> 1);
    assign d_try  = {r_drem[RW-2:0], r_dlow[DW-1]};

    // Memory port control
    always_comb begin
        pos_we    = in_acc && (i_kind == vna_pkg::KIND_LOAD)
                    && (VW'(i_vertex_index) < lim);
        pos_raddr = r_corner[r_cnt[1:0] == 2'd3 ? 2'd0 : r_cnt[1:0]];
        acc_we    = 1'b0;
        acc_waddr = r_idx;
        acc_raddr = r_idx;
        acc_wdata = '0;
        case (r_state)
            vna_pkg::S_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = r_clr_addr;
            end
            vna_pkg::S_TACC: begin
                acc_raddr = r_corner[sel == 2'd3 ? 2'd0 : sel];
                acc_waddr = r_corner[sel == 2'd3 ? 2'd0 : sel];
                acc_we    = r_cnt[0];
                acc_wdata = acc_sum;
            end
            vna_pkg::S_RCAP: begin
                acc_we = 1'b1;
            end
            default: begin
                acc_we = 1'b0;
            end
        endcase
    end

    // Position memory
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[i_vertex_index] <= {i_pos_z, i_pos_y, i_pos_x};
        end
        r_pos_rd <= pos_mem[pos_raddr];
    end

    // Accumulator memory
    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        r_acc_rd <= acc_mem[acc_raddr];
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VW'(vna_pkg::MAX_VERTICES);
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == vna_pkg::S_IDLE && r_cnt[0] && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == vna_pkg::S_IDLE && r_cnt[0] && out_free) begin
            r_out_status <= r_status;
            r_out_degen  <= r_degen;
            r_out_unnorm <= r_unnorm;
            for (int k = 0; k < 3; k++) begin
                r_out_nrm[k] <= r_nrm[k];
            end
        end
    end

    // Sequencer. In IDLE, r_cnt[0] marks a finished item still to be posted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= vna_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_cnt      <= '0;
            r_k        <= '0;
            r_degen    <= '0;
            r_unnorm   <= '0;
        end else begin
            case (r_state)
                // Zero the accumulators one entry a cycle
                vna_pkg::S_CLEAR: begin
                    r_cnt <= '0;
                    if (r_clr_addr == AW'(vna_pkg::MAX_VERTICES - 1)) begin
                        r_state <= vna_pkg::S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                // Post a finished item, then take the next one
                vna_pkg::S_IDLE: begin
                    if (r_cnt[0]) begin
                        if (out_free) begin
                            r_cnt <= '0;
                        end
                    end else if (in_acc) begin
                        r_idx       <= i_vertex_index;
                        r_corner[0] <= i_corner_a[AW-1:0];
                        r_corner[1] <= i_corner_b[AW-1:0];
                        r_corner[2] <= i_corner_c[AW-1:0];
                        for (int k = 0; k < 3; k++) begin
                            r_nrm[k] <= '0;
                        end
                        case (i_kind)
                            vna_pkg::KIND_LOAD: begin
                                r_cnt <= CW'(1);
                                if (VW'(i_vertex_index) >= lim) begin
                                    r_status <= vna_pkg::ST_RANGE;
                                end else begin
                                    r_status <= vna_pkg::ST_OK;
                                end
                            end
                            vna_pkg::KIND_TRI: begin
                                if (i_corner_a >= CRW'(lim) || i_corner_b >= CRW'(lim)
                                        || i_corner_c >= CRW'(lim)) begin
                                    r_status <= vna_pkg::ST_RANGE;
                                    r_cnt    <= CW'(1);
                                end else begin
                                    r_status <= vna_pkg::ST_OK;
                                    r_cnt    <= '0;
                                    r_state  <= vna_pkg::S_TRD;
                                end
                            end
                            vna_pkg::KIND_READ: begin
                                if (VW'(i_vertex_index) >= lim) begin
                                    r_status <= vna_pkg::ST_RANGE;
                                    r_cnt    <= CW'(1);
                                end else begin
                                    r_status <= vna_pkg::ST_OK;
                                    r_cnt    <= '0;
                                    r_state  <= vna_pkg::S_RRD;
                                end
                            end
                            default: begin
                                r_status <= vna_pkg::ST_OK;
                                r_cnt    <= CW'(1);
                            end
                        endcase
                    end
                end
                // Read the three corner positions
                vna_pkg::S_TRD: begin
                    if (r_cnt != '0) begin
                        for (int k = 0; k < 3; k++) begin
                            r_pos[r_cnt[1:0] - 2'd1][k] <= r_pos_rd[k*CB +: CB];
                        end
                    end
                    if (r_cnt == CW'(3)) begin
                        r_cnt   <= '0;
                        r_state <= vna_pkg::S_TEDGE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                // Form the edge vectors from corner 0 to corners 1 and 2
                vna_pkg::S_TEDGE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_e1[k] <= EW'(r_pos[1][k]) - EW'(r_pos[0][k]);
                        r_e2[k] <= EW'(r_pos[2][k]) - EW'(r_pos[0][k]);
                    end
                    r_state <= vna_pkg::S_TMUL;
                end
                // Products for one component a cycle, their difference in the cycle after
                vna_pkg::S_TMUL: begin
                    case (r_cnt[1:0])
                        2'd0: begin
                            r_p1 <= r_e1[1] * r_e2[2];
                            r_p2 <= r_e1[2] * r_e2[1];
                        end
                        2'd1: begin
                            r_p1 <= r_e1[2] * r_e2[0];
                            r_p2 <= r_e1[0] * r_e2[2];
                        end
                        2'd2: begin
                            r_p1 <= r_e1[0] * r_e2[1];
                            r_p2 <= r_e1[1] * r_e2[0];
                        end
                        default: begin
                            r_p1 <= '0;
                            r_p2 <= '0;
                        end
                    endcase
                    if (r_cnt != '0) begin
                        r_n[r_cnt[1:0] - 2'd1] <= XW'(r_p1) - XW'(r_p2);
                    end
                    if (r_cnt == CW'(3)) begin
                        r_cnt   <= '0;
                        r_state <= vna_pkg::S_TCHK;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                // Drop degenerate triangles
                vna_pkg::S_TCHK: begin
                    if (r_n[0] == '0 && r_n[1] == '0 && r_n[2] == '0) begin
                        if (r_degen != '1) begin
                            r_degen <= r_degen + TW'(1);
                        end
                        r_status <= vna_pkg::ST_DEGEN;
                        r_cnt    <= CW'(1);
                        r_state  <= vna_pkg::S_IDLE;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= vna_pkg::S_TACC;
                    end
                end
                // Read-modify-write each corner in turn
                vna_pkg::S_TACC: begin
                    if (r_cnt == CW'(5)) begin
                        r_cnt   <= CW'(1);
                        r_state <= vna_pkg::S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                // Read the sum
                vna_pkg::S_RRD: begin
                    r_state <= vna_pkg::S_RCAP;
                end
                // Capture magnitudes and signs, clear the entry
                vna_pkg::S_RCAP: begin
                    for (int k = 0; k < 3; k++) begin
                        r_u[k]   <= mag[k];
                        r_neg[k] <= a_rd[k][AB-1];
                    end
                    r_m     <= mag_max;
                    r_state <= vna_pkg::S_RNORM;
                end
                // Shift one bit a cycle until the largest lands in [2^29, 2^30); an all-zero sum ends as unnormed
                vna_pkg::S_RNORM: begin
                    if (r_m == '0) begin
                        if (r_unnorm != '1) begin
                            r_unnorm <= r_unnorm + TW'(1);
                        end
                        r_status <= vna_pkg::ST_UNNORMED;
                        r_cnt    <= CW'(1);
                        r_state  <= vna_pkg::S_IDLE;
                    end else if (r_m[AB-1:UW] != '0) begin
                        r_m <= r_m >> 1;
                        for (int k = 0; k < 3; k++) begin
                            r_u[k] <= r_u[k] >> 1;
                        end
                    end else if (!r_m[UW-1]) begin
                        r_m <= r_m << 1;
                        for (int k = 0; k < 3; k++) begin
                            r_u[k] <= r_u[k] << 1;
                        end
                    end else begin
                        r_cnt   <= '0;
                        r_s     <= '0;
                        r_state <= vna_pkg::S_RSQ;
                    end
                end
                // Sum of squares, one square a cycle
                vna_pkg::S_RSQ: begin
                    if (r_cnt != CW'(3)) begin
                        r_sq <= r_u[r_cnt[1:0]][UW-1:0] * r_u[r_cnt[1:0]][UW-1:0];
                    end
                    if (r_cnt != '0) begin
                        r_s <= r_s + SW'(r_sq);
                    end
                    if (r_cnt == CW'(3)) begin
                        r_root  <= '0;
                        r_bit   <= SW'(1) << (SW - 2);
                        r_state <= vna_pkg::S_RSQRT;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                // Integer square root, two bits of the radicand a cycle
                vna_pkg::S_RSQRT: begin
                    if (r_bit == '0) begin
                        r_len   <= r_root[LW-1:0];
                        r_k     <= '0;
                        r_cnt   <= '0;
                        r_state <= vna_pkg::S_RDIV;
                    end else begin
                        if (r_s >= sq_try) begin
                            r_s    <= r_s - sq_try;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                // Rounded divide by the length, one quotient bit a cycle
                vna_pkg::S_RDIV: begin
                    if (r_cnt == '0) begin
                        r_drem <= RW'(num[NW-1:DW]);
                        r_dlow <= num[DW-1:0];
                        r_quot <= '0;
                        r_cnt  <= CW'(1);
                    end else if (r_cnt <= CW'(DW)) begin
                        if (d_try >= RW'(r_len)) begin
                            r_drem <= d_try - RW'(r_len);
                            r_quot <= {r_quot[DW-2:0], 1'b1};
                        end else begin
                            r_drem <= d_try;
                            r_quot <= {r_quot[DW-2:0], 1'b0};
                        end
                        r_dlow <= r_dlow << 1;
                        r_cnt  <= r_cnt + CW'(1);
                    end else begin
                        r_nrm[r_k] <= r_neg[r_k] ? -$signed(r_quot) : $signed(r_quot);
                        if (r_k == 2'd2) begin
                            r_status <= vna_pkg::ST_OK;
                            r_cnt    <= CW'(1);
                            r_state  <= vna_pkg::S_IDLE;
                        end else begin
                            r_cnt <= '0;
                            r_k   <= r_k + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= vna_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_normal_x         = r_out_nrm[0];
    assign o_normal_y         = r_out_nrm[1];
    assign o_normal_z         = r_out_nrm[2];
    assign o_degenerate_total = r_out_degen;
    assign o_unnormed_total   = r_out_unnorm;

endmodule

### src/vna_checker.sv
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks for the vertex normal accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module vna_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         o_status,
    input  logic signed [15:0] o_normal_x,
    input  logic signed [15:0] o_normal_y,
    input  logic signed [15:0] o_normal_z
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    // Normals are zero on any result with a failure status
    a_zero_nrm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != vna_pkg::ST_OK
            |-> o_normal_x == 16'sd0 && o_normal_y == 16'sd0 && o_normal_z == 16'sd0)
        else $error("nonzero normal on failed item");

    // Normal components stay within unit range
    a_nrm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384
            && o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384
            && o_normal_z <= 16'sd16384 && o_normal_z >= -16'sd16384)
        else $error("normal out of range");

    // Ready stays low as reset is released, while the clearing pass runs
    a_clear_busy: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_in_ready)
        else $error("item accepted during clearing pass");

endmodule

bind vertex_normal_accumulator_core vna_checker u_vna_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_normal_x  (o_normal_x),
    .o_normal_y  (o_normal_y),
    .o_normal_z  (o_normal_z)
);
